FILE: hdl/assert_macros.svh
// assertion helpers used by the parser core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// trigger in one cycle implies result in the next cycle
`define ASSERT_NEXT(label, clk, rst, trig, res, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (res)) else $error(msg);

`endif

FILE: hdl/mnp_pkg.sv
`default_nettype none

package mnp_pkg;

   // result queue geometry
   localparam int RES_DEPTH = 4;
   localparam int RES_PTR_W = $clog2(RES_DEPTH);
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

   // register indexes on the csr port
   localparam logic CSR_OCTAVE_FLOOR   = 1'b0;
   localparam logic CSR_OCTAVE_CEILING = 1'b1;

   // reset values of the octave bounds
   localparam logic signed [3:0] OCTAVE_FLOOR_RESET   = -4'sd3;
   localparam logic        [2:0] OCTAVE_CEILING_RESET = 3'd3;

   // tune characters
   localparam logic [7:0] CHR_SHARP   = 8'h23;  // '#'
   localparam logic [7:0] CHR_FLAT    = 8'h21;  // '!'
   localparam logic [7:0] CHR_PLUS    = 8'h2b;
   localparam logic [7:0] CHR_MINUS   = 8'h2d;
   localparam logic [7:0] CHR_DOT     = 8'h2e;
   localparam logic [7:0] CHR_ZERO    = 8'h30;
   localparam logic [7:0] CHR_THREE   = 8'h33;
   localparam logic [7:0] CHR_NINE    = 8'h39;
   localparam logic [7:0] CHR_A       = 8'h41;
   localparam logic [7:0] CHR_G       = 8'h47;
   localparam logic [7:0] CHR_H       = 8'h48;
   localparam logic [7:0] CHR_I       = 8'h49;
   localparam logic [7:0] CHR_Q       = 8'h51;
   localparam logic [7:0] CHR_S       = 8'h53;
   localparam logic [7:0] CHR_T       = 8'h54;
   localparam logic [7:0] CHR_W       = 8'h57;
   localparam logic [7:0] CHR_X       = 8'h58;
   localparam logic [7:0] CHR_LOWER_A = 8'h61;
   localparam logic [7:0] CHR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [3:0] PITCH_TOP = 4'd11;
   localparam logic [2:0] DOT_MAX   = 3'd7;

   typedef enum logic [1:0] {
      KIND_END  = 2'd0,
      KIND_NOTE = 2'd1,
      KIND_REST = 2'd2,
      KIND_DRUM = 2'd3
   } event_kind_type;

   typedef enum logic [2:0] {
      DUR_THIRTYSECOND = 3'd0,
      DUR_SIXTEENTH    = 3'd1,
      DUR_EIGHTH       = 3'd2,
      DUR_QUARTER      = 3'd3,
      DUR_HALF         = 3'd4,
      DUR_WHOLE        = 3'd5
   } duration_type;

   // running parser state
   typedef struct packed {
      logic [2:0]        duration;
      logic              triplet;
      logic [2:0]        dots;
      logic signed [3:0] octave;
      logic              pend_valid;
      logic [3:0]        pend_pitch;
   } parse_state_type;

   // one result record
   typedef struct packed {
      event_kind_type    kind;
      logic [3:0]        pitch;
      logic signed [3:0] octave;
      logic [2:0]        duration;
      logic              triplet;
      logic [2:0]        dots;
      logic              last;
   } result_type;

   // semitone of note letters A to G
   function automatic logic [3:0] letter_pitch(input logic [2:0] idx);
      logic [3:0] p;
      case (idx)
         3'd0:    p = 4'd9;
         3'd1:    p = 4'd11;
         3'd2:    p = 4'd0;
         3'd3:    p = 4'd2;
         3'd4:    p = 4'd4;
         3'd5:    p = 4'd5;
         3'd6:    p = 4'd7;
         default: p = 4'd0;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/music_string_note_parser_core.sv
// channel  dir  ports                          contents
// req      in   req_tvalid/tready/tdata/tuser  tdata: symbol; tuser: end_of_tune
// rsp      out  rsp_tvalid/tready/tdata/tuser  tdata: note fields; tuser: kind; tlast
// csr      in   csr_valid/ready/index/data     octave floor and ceiling writes
//
// one request per cycle is taken while the result queue has two free slots
// results of a request are written to the result queue when it is accepted and wait there behind older results
// a request with two results puts both records on the result port in turn
// reset is synchronous, no clearing pass
// a stalled result port drops req_tready once three of the four queue entries are used
`default_nettype none
`include "assert_macros.svh"

module music_string_note_parser_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] symbol
   input  wire logic        req_tuser,   // [0] end_of_tune
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] pitch_class, [7:4] octave, [10:8] duration_code, [11] is_triplet,
   // [14:12] dot_count, [15] zero
   output logic [15:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,   // [1:0] event_kind
   output logic             rsp_tlast,   // last_result
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [3:0]  csr_data
);
   import mnp_pkg::*;

   parse_state_type      state_ff;
   parse_state_type      state_in;
   logic signed [3:0]    floor_ff;
   logic [2:0]           ceiling_ff;
   result_type           res_first;
   result_type           res_second;
   result_type           res_head;
   logic [1:0]           res_count;
   logic [1:0]           push_count;
   logic                 room_for_two;
   logic                 req_accept;
   logic [RES_CNT_W-1:0] fill;

   assign csr_ready  = 1'b1;
   assign req_tready = room_for_two;
   assign req_accept = req_tvalid && req_tready;
   assign push_count = req_accept ? res_count : 2'd0;

   // character decode
   mnp_decode u_decode (
      .symbol         (req_tdata),
      .end_of_tune    (req_tuser),
      .state_now      (state_ff),
      .octave_floor   (floor_ff),
      .octave_ceiling (ceiling_ff),
      .state_in       (state_in),
      .res_first      (res_first),
      .res_second     (res_second),
      .res_count      (res_count)
   );

   // parser state, updated on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // octave bound registers
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= OCTAVE_FLOOR_RESET;
         ceiling_ff <= OCTAVE_CEILING_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OCTAVE_FLOOR:   floor_ff   <= csr_data;
            CSR_OCTAVE_CEILING: ceiling_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // result queue
   mnp_result_fifo u_result_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push_first   (res_first),
      .push_second  (res_second),
      .room_for_two (room_for_two),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_data     (res_head),
      .fill         (fill)
   );

   // result port packing
   assign rsp_tdata = {1'b0, res_head.dots, res_head.triplet, res_head.duration,
                       res_head.octave, res_head.pitch};
   assign rsp_tuser = res_head.kind;
   assign rsp_tlast = res_head.last;

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill <= RES_CNT_W'(RES_DEPTH), "result queue overflow")
   `ASSERT_NEXT(a_end_clears_pending, clock, reset, req_accept && req_tuser, !state_ff.pend_valid, "pending note survived end of tune")
   `ASSERT_NEXT(a_end_gives_result, clock, reset, req_accept && req_tuser, rsp_tvalid, "end of tune produced no result")

endmodule

`default_nettype wire

FILE: hdl/mnp_decode.sv
`default_nettype none

module mnp_decode (
   input  wire logic [7:0]                 symbol,
   input  wire logic                       end_of_tune,
   input  wire mnp_pkg::parse_state_type   state_now,
   input  wire logic signed [3:0]          octave_floor,
   input  wire logic [2:0]                 octave_ceiling,
   output mnp_pkg::parse_state_type        state_in,
   output mnp_pkg::result_type             res_first,
   output mnp_pkg::result_type             res_second,
   output logic [1:0]                      res_count
);
   import mnp_pkg::*;

   logic [7:0]        chr;
   logic signed [4:0] oct_wide;
   logic signed [4:0] floor_wide;
   logic signed [4:0] ceil_wide;
   logic signed [4:0] oct_up;
   logic signed [4:0] oct_down;
   logic              is_letter;
   logic              is_drum;
   result_type        base;

   // case folding and widened octave arithmetic
   always_comb begin
      chr = symbol;
      if (symbol >= CHR_LOWER_A && symbol <= CHR_LOWER_Z) begin
         chr = symbol - CASE_OFFSET;
      end
      oct_wide   = {state_now.octave[3], state_now.octave};
      floor_wide = {octave_floor[3], octave_floor};
      ceil_wide  = {2'b00, octave_ceiling};
      oct_up     = oct_wide + 5'sd1;
      oct_down   = oct_wide - 5'sd1;
      is_letter  = (chr >= CHR_A) && (chr <= CHR_G);
      is_drum    = (chr >= CHR_ZERO) && (chr <= CHR_NINE) && (chr != CHR_THREE);
   end

   // record with the settings in force before this character
   always_comb begin
      base.kind     = KIND_NOTE;
      base.pitch    = state_now.pend_pitch;
      base.octave   = state_now.octave;
      base.duration = state_now.duration;
      base.triplet  = state_now.triplet;
      base.dots     = state_now.dots;
      base.last     = 1'b0;
   end

   // results and next state
   always_comb begin
      state_in   = state_now;
      res_first  = base;
      res_second = base;
      res_count  = 2'd0;

      if (end_of_tune) begin
         // flush the held note, then the end marker
         state_in.pend_valid = 1'b0;
         res_second.kind  = KIND_END;
         res_second.pitch = 4'd0;
         res_second.last  = 1'b1;
         if (state_now.pend_valid) begin
            res_count = 2'd2;
         end else begin
            res_first = res_second;
            res_count = 2'd1;
         end
      end else if (state_now.pend_valid && (chr == CHR_SHARP || chr == CHR_FLAT)) begin
         // accidental is consumed by the held note
         state_in.pend_valid = 1'b0;
         res_first.last = 1'b1;
         res_count = 2'd1;
         if (chr == CHR_SHARP) begin
            if (state_now.pend_pitch == PITCH_TOP) begin
               res_first.pitch  = 4'd0;
               res_first.octave = (oct_up > ceil_wide) ? ceil_wide[3:0] : oct_up[3:0];
            end else begin
               res_first.pitch = state_now.pend_pitch + 4'd1;
            end
         end else begin
            if (state_now.pend_pitch == 4'd0) begin
               res_first.pitch  = PITCH_TOP;
               res_first.octave = (oct_down < floor_wide) ? floor_wide[3:0] : oct_down[3:0];
            end else begin
               res_first.pitch = state_now.pend_pitch - 4'd1;
            end
         end
      end else begin
         state_in.pend_valid = 1'b0;

         // setting changes
         case (chr)
            CHR_T: begin
               state_in.duration = DUR_THIRTYSECOND;
               state_in.triplet  = 1'b0;
               state_in.dots     = 3'd0;
            end
            CHR_S: begin
               state_in.duration = DUR_SIXTEENTH;
               state_in.triplet  = 1'b0;
               state_in.dots     = 3'd0;
            end
            CHR_I: begin
               state_in.duration = DUR_EIGHTH;
               state_in.triplet  = 1'b0;
               state_in.dots     = 3'd0;
            end
            CHR_Q: begin
               state_in.duration = DUR_QUARTER;
               state_in.triplet  = 1'b0;
               state_in.dots     = 3'd0;
            end
            CHR_H: begin
               state_in.duration = DUR_HALF;
               state_in.triplet  = 1'b0;
               state_in.dots     = 3'd0;
            end
            CHR_W: begin
               state_in.duration = DUR_WHOLE;
               state_in.triplet  = 1'b0;
               state_in.dots     = 3'd0;
            end
            CHR_THREE: state_in.triplet = 1'b1;
            CHR_DOT: begin
               if (state_now.dots < DOT_MAX) begin
                  state_in.dots = state_now.dots + 3'd1;
               end
            end
            CHR_PLUS: begin
               if (oct_wide < ceil_wide) begin
                  state_in.octave = oct_up[3:0];
               end
            end
            CHR_MINUS: begin
               if (oct_wide > floor_wide) begin
                  state_in.octave = oct_down[3:0];
               end
            end
            default: ;
         endcase

         // new note letter is held for one character
         if (is_letter) begin
            state_in.pend_valid = 1'b1;
            state_in.pend_pitch = letter_pitch(3'(chr - CHR_A));
         end

         // rest or drum record, settings are unchanged by these characters
         res_second.pitch = 4'd0;
         res_second.last  = 1'b1;
         if (chr == CHR_X) begin
            res_second.kind = KIND_REST;
         end else begin
            res_second.kind  = KIND_DRUM;
            res_second.pitch = chr[3:0];
         end

         // assemble the held note and the immediate record
         if (state_now.pend_valid) begin
            if (chr == CHR_X || is_drum) begin
               res_count = 2'd2;
            end else begin
               res_first.last = 1'b1;
               res_count = 2'd1;
            end
         end else if (chr == CHR_X || is_drum) begin
            res_first = res_second;
            res_count = 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

FILE: hdl/mnp_result_fifo.sv
`default_nettype none

module mnp_result_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [1:0]           push_count,
   input  wire mnp_pkg::result_type  push_first,
   input  wire mnp_pkg::result_type  push_second,
   output logic                      room_for_two,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output mnp_pkg::result_type       out_data,
   output logic [mnp_pkg::RES_CNT_W-1:0] fill
);
   import mnp_pkg::*;

   result_type           entry_ff [RES_DEPTH];
   logic [RES_PTR_W-1:0] wr_ptr_ff;
   logic [RES_PTR_W-1:0] wr_ptr_in;
   logic [RES_PTR_W-1:0] wr_next;
   logic [RES_PTR_W-1:0] rd_ptr_ff;
   logic [RES_PTR_W-1:0] rd_ptr_in;
   logic [RES_CNT_W-1:0] count_ff;
   logic [RES_CNT_W-1:0] count_in;
   logic                 pop;

   // status toward both sides
   always_comb begin
      out_valid    = (count_ff != '0);
      out_data     = entry_ff[rd_ptr_ff];
      room_for_two = (count_ff <= RES_CNT_W'(RES_DEPTH - 2));
      fill         = count_ff;
      pop          = out_valid && out_ready;
      wr_next      = wr_ptr_ff + RES_PTR_W'(1);
      wr_ptr_in    = wr_ptr_ff + RES_PTR_W'(push_count);
      rd_ptr_in    = pop ? rd_ptr_ff + RES_PTR_W'(1) : rd_ptr_ff;
      count_in     = count_ff + RES_CNT_W'(push_count) - RES_CNT_W'(pop);
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // record storage, up to two writes per cycle
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next] <= push_second;
      end
   end

endmodule

`default_nettype wire

FILE: verif/note_stream_checker.sv
`timescale 1ns / 1ps

module note_stream_checker
   import mnp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [3:0]  csr_data,
   output int          error_count,
   output int          expected_left,
   output int          requests_seen,
   output int          notes_seen,
   output int          rests_seen,
   output int          drums_seen,
   output int          ends_seen
);

   // octave bounds as programmed
   int floor_lim;
   int ceil_lim;

   // running tune settings
   logic [2:0] dur_now;
   logic       trip_now;
   logic [2:0] dots_now;
   int         oct_now;
   logic       held_valid;
   logic [3:0] held_pitch;

   result_type expected_events[$];

   initial begin
      error_count   = 0;
      expected_left = 0;
      requests_seen = 0;
      notes_seen    = 0;
      rests_seen    = 0;
      drums_seen    = 0;
      ends_seen     = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 40) begin
         $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      end
      error_count++;
   endtask

   function automatic result_type make_event(input event_kind_type kind,
                                             input logic [3:0] pitch, input int oct);
      result_type ev;
      ev.kind     = kind;
      ev.pitch    = pitch;
      ev.octave   = 4'(oct);
      ev.duration = dur_now;
      ev.triplet  = trip_now;
      ev.dots     = dots_now;
      ev.last     = 1'b0;
      return ev;
   endfunction

   // semitone of a note letter, c already folded to upper case
   function automatic logic [3:0] semitone_of(input logic [7:0] c);
      logic [3:0] p;
      case (c)
         8'h41:   p = 4'd9;   // A
         8'h42:   p = 4'd11;  // B
         8'h43:   p = 4'd0;   // C
         8'h44:   p = 4'd2;   // D
         8'h45:   p = 4'd4;   // E
         8'h46:   p = 4'd5;   // F
         default: p = 4'd7;   // G
      endcase
      return p;
   endfunction

   // work out the events one request causes and queue them
   task automatic predict_events(input logic [7:0] sym, input logic eot);
      result_type evs[$];
      logic [7:0] c;
      logic [3:0] p;
      int         o;
      bit         consumed;
      c = sym;
      consumed = 1'b0;
      if (eot) begin
         // flush a held note, then the end marker
         if (held_valid) evs.push_back(make_event(KIND_NOTE, held_pitch, oct_now));
         held_valid = 1'b0;
         evs.push_back(make_event(KIND_END, 4'd0, oct_now));
      end else begin
         if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) c = c - CASE_OFFSET;
         // a held note goes out first, possibly bent by this character
         if (held_valid) begin
            p = held_pitch;
            o = oct_now;
            held_valid = 1'b0;
            if (c == CHR_SHARP) begin
               consumed = 1'b1;
               if (p == PITCH_TOP) begin
                  p = 4'd0;
                  o = o + 1;
                  if (o > ceil_lim) o = ceil_lim;
               end else begin
                  p = p + 4'd1;
               end
            end else if (c == CHR_FLAT) begin
               consumed = 1'b1;
               if (p == 4'd0) begin
                  p = PITCH_TOP;
                  o = o - 1;
                  if (o < floor_lim) o = floor_lim;
               end else begin
                  p = p - 4'd1;
               end
            end
            evs.push_back(make_event(KIND_NOTE, p, o));
         end
         if (!consumed) begin
            // settings changes
            case (c)
               CHR_T: begin
                  dur_now = DUR_THIRTYSECOND; trip_now = 1'b0; dots_now = 3'd0;
               end
               CHR_S: begin
                  dur_now = DUR_SIXTEENTH; trip_now = 1'b0; dots_now = 3'd0;
               end
               CHR_I: begin
                  dur_now = DUR_EIGHTH; trip_now = 1'b0; dots_now = 3'd0;
               end
               CHR_Q: begin
                  dur_now = DUR_QUARTER; trip_now = 1'b0; dots_now = 3'd0;
               end
               CHR_H: begin
                  dur_now = DUR_HALF; trip_now = 1'b0; dots_now = 3'd0;
               end
               CHR_W: begin
                  dur_now = DUR_WHOLE; trip_now = 1'b0; dots_now = 3'd0;
               end
               CHR_THREE: trip_now = 1'b1;
               CHR_DOT: begin
                  if (dots_now < DOT_MAX) dots_now = dots_now + 3'd1;
               end
               CHR_PLUS: begin
                  if (oct_now < ceil_lim) oct_now = oct_now + 1;
               end
               CHR_MINUS: begin
                  if (oct_now > floor_lim) oct_now = oct_now - 1;
               end
               default: ;
            endcase
            // events of this character
            if (c >= CHR_A && c <= CHR_G) begin
               held_valid = 1'b1;
               held_pitch = semitone_of(c);
            end else if (c == CHR_X) begin
               evs.push_back(make_event(KIND_REST, 4'd0, oct_now));
            end else if (c >= CHR_ZERO && c <= CHR_NINE && c != CHR_THREE) begin
               evs.push_back(make_event(KIND_DRUM, 4'(c - CHR_ZERO), oct_now));
            end
         end
      end
      if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
      foreach (evs[i]) expected_events.push_back(evs[i]);
   endtask

   // compare one result with the oldest expected event
   task automatic check_result();
      result_type want;
      if (expected_events.size() == 0) begin
         report_mismatch("result with nothing expected, kind", int'(rsp_tuser), -1);
         return;
      end
      want = expected_events.pop_front();
      if (rsp_tuser !== want.kind)
         report_mismatch("event kind", int'(rsp_tuser), int'(want.kind));
      if (rsp_tdata[3:0] !== want.pitch)
         report_mismatch("pitch class", int'(rsp_tdata[3:0]), int'(want.pitch));
      if (rsp_tdata[7:4] !== want.octave)
         report_mismatch("octave", int'($signed(rsp_tdata[7:4])), int'(want.octave));
      if (rsp_tdata[10:8] !== want.duration)
         report_mismatch("duration code", int'(rsp_tdata[10:8]), int'(want.duration));
      if (rsp_tdata[11] !== want.triplet)
         report_mismatch("triplet flag", int'(rsp_tdata[11]), int'(want.triplet));
      if (rsp_tdata[14:12] !== want.dots)
         report_mismatch("dot count", int'(rsp_tdata[14:12]), int'(want.dots));
      if (rsp_tdata[15] !== 1'b0)
         report_mismatch("tdata pad bit", int'(rsp_tdata[15]), 0);
      if (rsp_tlast !== want.last)
         report_mismatch("last flag", int'(rsp_tlast), int'(want.last));
      case (want.kind)
         KIND_NOTE: notes_seen++;
         KIND_REST: rests_seen++;
         KIND_DRUM: drums_seen++;
         default:   ends_seen++;
      endcase
   endtask

   // watch the three channels on each rising edge
   always @(posedge clock) begin
      if (reset) begin
         floor_lim  = int'(OCTAVE_FLOOR_RESET);
         ceil_lim   = int'(OCTAVE_CEILING_RESET);
         dur_now    = DUR_THIRTYSECOND;
         trip_now   = 1'b0;
         dots_now   = 3'd0;
         oct_now    = 0;
         held_valid = 1'b0;
         held_pitch = 4'd0;
         expected_events.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_OCTAVE_FLOOR) floor_lim = $signed(csr_data);
            else ceil_lim = int'(csr_data[2:0]);
         end
         if (req_tvalid && req_tready) begin
            requests_seen++;
            predict_events(req_tdata, req_tuser);
         end
         if (rsp_tvalid && rsp_tready) check_result();
      end
      expected_left = expected_events.size();
   end

endmodule

FILE: verif/music_string_note_parser_core_tb.sv
`timescale 1ns / 1ps

module music_string_note_parser_core_tb;
   import mnp_pkg::*;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] symbol
   logic        req_tuser  = 1'b0;   // [0] end_of_tune
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [3:0] pitch_class, [7:4] octave, [10:8] duration_code, [11] is_triplet,
   // [14:12] dot_count, [15] zero
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;           // [1:0] event_kind
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [3:0]  csr_data   = 4'd0;

   int error_count;
   int expected_left;
   int requests_seen;
   int notes_seen;
   int rests_seen;
   int drums_seen;
   int ends_seen;

   // handshake timing knobs
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   music_string_note_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   note_stream_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .expected_left (expected_left),
      .requests_seen (requests_seen),
      .notes_seen    (notes_seen),
      .rests_seen    (rests_seen),
      .drums_seen    (drums_seen),
      .ends_seen     (ends_seen)
   );

   // result side: long hold-off first, otherwise random stalls
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // offer one request after a random gap and wait for it to be taken
   task automatic send_request(input logic [7:0] sym, input logic eot);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tuser  <= eot;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_request(text[i], 1'b0);
   endtask

   // stop offering and wait until every expected event has come back
   task automatic drain_events();
      int guard;
      guard = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_left != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
   endtask

   task automatic write_register(input logic idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 4'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // idle the block, then set both octave bounds
   task automatic set_bounds(input int lo, input int hi);
      drain_events();
      repeat (4) @(negedge clock);
      write_register(CSR_OCTAVE_FLOOR, lo);
      write_register(CSR_OCTAVE_CEILING, hi);
   endtask

   // random tune fragments, mostly well formed, some noise
   task automatic run_random_tune(input int target);
      int         made;
      int         pick;
      int         run;
      logic [7:0] ch;
      made = 0;
      while (made < target) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            // note letter, often with an accidental
            ch = CHR_A + 8'($urandom_range(6));
            if ($urandom_range(1)) ch = ch | CASE_OFFSET;
            send_request(ch, 1'b0);
            made++;
            case ($urandom_range(3))
               0: begin send_request(CHR_SHARP, 1'b0); made++; end
               1: begin send_request(CHR_FLAT, 1'b0); made++; end
               default: ;
            endcase
         end else if (pick < 42) begin
            case ($urandom_range(5))
               0:       ch = CHR_T;
               1:       ch = CHR_S;
               2:       ch = CHR_I;
               3:       ch = CHR_Q;
               4:       ch = CHR_H;
               default: ch = CHR_W;
            endcase
            if ($urandom_range(1)) ch = ch | CASE_OFFSET;
            send_request(ch, 1'b0);
            made++;
         end else if (pick < 47) begin
            send_request(CHR_THREE, 1'b0);
            made++;
         end else if (pick < 55) begin
            // dot runs, long enough to saturate now and then
            run = $urandom_range(9, 1);
            repeat (run) send_request(CHR_DOT, 1'b0);
            made += run;
         end else if (pick < 65) begin
            // octave runs that reach the bounds
            run = $urandom_range(10, 1);
            ch  = $urandom_range(1) ? CHR_PLUS : CHR_MINUS;
            repeat (run) send_request(ch, 1'b0);
            made += run;
         end else if (pick < 72) begin
            send_request($urandom_range(1) ? CHR_X : (CHR_X | CASE_OFFSET), 1'b0);
            made++;
         end else if (pick < 80) begin
            send_request(CHR_ZERO + 8'($urandom_range(9)), 1'b0);
            made++;
         end else if (pick < 86) begin
            send_request(8'($urandom_range(255)), 1'b1);
            made++;
         end else begin
            send_request(8'($urandom_range(255)), 1'b0);
         end
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: accidentals at both wrap points, all durations, rest, drums
      send_text("c#b#C!t3.x09+d");
      send_request(CHR_G, 1'b1);
      send_text("hI");
      send_request(8'hff, 1'b0);
      send_text("sQ.W-");
      send_request(8'h00, 1'b0);
      send_request(8'h00, 1'b1);

      // widest bounds, no idling
      set_bounds(-8, 7);
      run_random_tune(50);

      // result side held off while requests keep coming
      drain_events();
      hold_left = 60;
      for (int i = 0; i < 20; i++)
         send_request((i % 3 == 0) ? CHR_X : CHR_ZERO + 8'(i % 10), 1'b0);

      // pinned bounds, sender mostly idle
      set_bounds(0, 0);
      send_idle_pct = 83;
      run_random_tune(50);

      // narrow bounds, receiver mostly stalled
      set_bounds(-1, 2);
      send_idle_pct  = 0;
      recv_stall_pct = 83;
      run_random_tune(50);

      // random bounds, both sides idling now and then
      set_bounds($urandom_range(8) - 8, $urandom_range(7));
      send_idle_pct  = 23;
      recv_stall_pct = 23;
      run_random_tune(50);

      drain_events();
      repeat (10) @(negedge clock);

      $display("covered %0d requests: %0d notes, %0d rests, %0d drums, %0d end markers",
               requests_seen, notes_seen, rests_seen, drums_seen, ends_seen);
      $display("octave bounds from -8..7 down to 0..0, under four handshake timing mixes");
      if (expected_left != 0)
         $display("events never delivered: %0d", expected_left);
      if (error_count == 0 && expected_left == 0) begin
         $display("music_string_note_parser_core_tb: clean");
      end else begin
         $display("music_string_note_parser_core_tb: errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #400000;
      $display("music_string_note_parser_core_tb: errors");
      $finish;
   end

endmodule
